[rtl/core/ssd_pkg.sv]
package ssd_pkg;

    // Request kinds.
    localparam logic [1:0] KIND_INT  = 2'd0;
    localparam logic [1:0] KIND_RAW  = 2'd1;
    localparam logic [1:0] KIND_TEXT = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 12;
    localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACHED   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLANK      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MINUS      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DASH       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_LETTER_E   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_LETTER_R   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPACE      = 3'd7;

    // Link command bytes.
    localparam logic [7:0] CMD_DATA_AUTO    = 8'h40;
    localparam logic [7:0] CMD_ADDR_START   = 8'hC0;
    localparam logic [7:0] CMD_DISPLAY_CTRL = 8'h88;

    // Integer clipping range.
    localparam logic signed [15:0] CLIP_HIGH = 16'sd9999;
    localparam logic signed [15:0] CLIP_LOW  = -16'sd999;

    // Reciprocals for division by 10, 100 and 1000 of values up to 9999.
    localparam logic [13:0] RECIP_DIV10   = 14'd6554;   // shift 16
    localparam logic [13:0] RECIP_DIV100  = 14'd10486;  // shift 20
    localparam logic [13:0] RECIP_DIV1000 = 14'd8389;   // shift 23

    // Characters recognized in text requests.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_E     = 8'h45;
    localparam logic [7:0] CHAR_R     = 8'h72;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    // Configurable segment patterns.
    typedef struct packed {
        logic [7:0] blank;
        logic [7:0] minus;
        logic [7:0] dash;
        logic [7:0] letter_e;
        logic [7:0] letter_r;
        logic [7:0] space;
    } seg_codes_t;

    // Request after the divide stage.
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  display;
        logic        neg;
        logic [13:0] mag;
        logic [9:0]  q10;
        logic [6:0]  q100;
        logic [3:0]  q1000;
        logic [31:0] seg;
    } stage_t;

    // Position within one seven-byte frame.
    typedef enum logic [2:0] {
        SLOT_DATA_CMD = 3'd0,
        SLOT_ADDR_CMD = 3'd1,
        SLOT_DIGIT0   = 3'd2,
        SLOT_DIGIT1   = 3'd3,
        SLOT_DIGIT2   = 3'd4,
        SLOT_DIGIT3   = 3'd5,
        SLOT_CTRL     = 3'd6
    } frame_slot_t;

    function automatic logic [7:0] digit_pattern(input logic [3:0] value);
        logic [7:0] pat;
        unique case (value)
            4'd0:    pat = 8'h3F;
            4'd1:    pat = 8'h06;
            4'd2:    pat = 8'h5B;
            4'd3:    pat = 8'h4F;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'h6D;
            4'd6:    pat = 8'h7D;
            4'd7:    pat = 8'h07;
            4'd8:    pat = 8'h7F;
            4'd9:    pat = 8'h6F;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

[rtl/core/ssd_front.sv]
module ssd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [1:0]         kind,
    input  logic [1:0]         display,
    input  logic signed [15:0] number,
    input  logic [31:0]        segments,
    input  logic [31:0]        text,
    input  ssd_pkg::seg_codes_t codes,
    output logic               stage_valid,
    input  logic               stage_ready,
    output ssd_pkg::stage_t    stage
);
    import ssd_pkg::*;

    logic               s1_valid_reg;
    logic [1:0]         s1_kind_reg;
    logic [1:0]         s1_display_reg;
    logic signed [15:0] s1_number_reg;
    logic [31:0]        s1_segments_reg;
    logic [31:0]        s1_text_reg;

    logic               s2_valid_reg;
    stage_t             s2_reg;
    stage_t             s2_next;

    logic               s2_free;
    logic               s1_move;
    logic               accept;

    logic signed [15:0] clipped;
    logic [13:0]        mag;
    logic [27:0]        prod10;
    logic [27:0]        prod100;
    logic [27:0]        prod1000;
    logic [31:0]        text_seg;

    assign s2_free   = !s2_valid_reg || stage_ready;
    assign s1_move   = s1_valid_reg && s2_free;
    assign req_ready = !s1_valid_reg || s2_free;
    assign accept    = req_valid && req_ready;

    // Clip and take the magnitude, then split it into quotients by 10, 100
    // and 1000 with reciprocal multiplies.
    always_comb
    begin
        clipped = s1_number_reg;
        if (s1_number_reg > CLIP_HIGH)
        begin
            clipped = CLIP_HIGH;
        end
        else if (s1_number_reg < CLIP_LOW)
        begin
            clipped = CLIP_LOW;
        end
        mag      = clipped[15] ? 14'(-clipped) : 14'(clipped);
        prod10   = 28'(mag) * 28'(RECIP_DIV10);
        prod100  = 28'(mag) * 28'(RECIP_DIV100);
        prod1000 = 28'(mag) * 28'(RECIP_DIV1000);
    end

    // Text characters; everything from the first NUL byte on is blank.
    always_comb
    begin
        logic       ended;
        logic [7:0] ch;
        logic [7:0] pat;
        ended = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            ch = s1_text_reg[8*i +: 8];
            pat = codes.blank;
            if (ch == CHAR_NUL)
            begin
                ended = 1'b1;
            end
            if (!ended)
            begin
                if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
                begin
                    pat = digit_pattern(4'(ch - CHAR_ZERO));
                end
                else if (ch == CHAR_DASH)
                begin
                    pat = codes.dash;
                end
                else if (ch == CHAR_E)
                begin
                    pat = codes.letter_e;
                end
                else if (ch == CHAR_R)
                begin
                    pat = codes.letter_r;
                end
                else if (ch == CHAR_SPACE)
                begin
                    pat = codes.space;
                end
            end
            text_seg[8*i +: 8] = pat;
        end
    end

    always_comb
    begin
        s2_next.kind    = s1_kind_reg;
        s2_next.display = s1_display_reg;
        s2_next.neg     = clipped[15];
        s2_next.mag     = mag;
        s2_next.q10     = prod10[25:16];
        s2_next.q100    = prod100[26:20];
        s2_next.q1000   = prod1000[26:23];
        s2_next.seg     = (s1_kind_reg == KIND_RAW) ? s1_segments_reg : text_seg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg     <= kind;
            s1_display_reg  <= display;
            s1_number_reg   <= number;
            s1_segments_reg <= segments;
            s1_text_reg     <= text;
        end
        if (s1_move)
        begin
            s2_reg <= s2_next;
        end
    end

    assign stage_valid = s2_valid_reg;
    assign stage       = s2_reg;

endmodule

[rtl/core/ssd_update.sv]
module ssd_update #(
    parameter int NUM_DISPLAYS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                stage_valid,
    output logic                stage_ready,
    input  ssd_pkg::stage_t     stage,
    input  logic [11:0]         brightness_codes,
    input  logic [3:0]          attached_mask,
    input  ssd_pkg::seg_codes_t codes,
    output logic                frame_valid,
    input  logic                frame_ready,
    output logic [1:0]          target,
    output logic [7:0]          frame_byte,
    output logic                start_before,
    output logic                stop_after,
    output logic                last
);
    import ssd_pkg::*;

    localparam int CACHE_DEPTH = (NUM_DISPLAYS < 4) ? NUM_DISPLAYS : 4;
    localparam int IDX_W       = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int CACHE_SIZE  = 2 ** IDX_W;
    localparam logic [3:0] DISPLAY_LIMIT = 4'(NUM_DISPLAYS);

    logic [CACHE_SIZE-1:0] cache_valid_reg;
    logic [31:0]           cache_seg_reg [CACHE_SIZE];
    logic [2:0]            cache_br_reg  [CACHE_SIZE];

    logic                  busy_reg;
    logic                  busy_next;
    frame_slot_t           slot_reg;
    frame_slot_t           slot_next;
    logic [1:0]            tgt_reg;
    logic [31:0]           seg_reg;
    logic [2:0]            br_reg;

    logic [IDX_W-1:0]      idx;
    logic [3:0]            d0, d1, d2, d3;
    logic [7:0]            int_seg0, int_seg1, int_seg2, int_seg3;
    logic [31:0]           packed_seg;
    logic [3:0]            br_lsb;
    logic [2:0]            br;
    logic                  kind_ok;
    logic                  in_range;
    logic                  hit;
    logic                  emit;
    logic                  last_byte;
    logic                  em_free;
    logic                  load;

    assign idx = stage.display[IDX_W-1:0];

    // Decimal digits from the registered quotients.
    assign d3 = 4'(stage.mag - 14'({stage.q10, 3'b000}) - 14'({stage.q10, 1'b0}));
    assign d2 = 4'(stage.q10 - 10'({stage.q100, 3'b000}) - 10'({stage.q100, 1'b0}));
    assign d1 = 4'(stage.q100 - 7'({stage.q1000, 3'b000}) - 7'({stage.q1000, 1'b0}));
    assign d0 = stage.q1000;

    // Right-aligned, leading positions blank while the remaining quotient is zero.
    assign int_seg3 = digit_pattern(d3);
    assign int_seg2 = (stage.q10 != '0) ? digit_pattern(d2) : codes.blank;
    assign int_seg1 = (stage.q100 != '0) ? digit_pattern(d1) : codes.blank;
    assign int_seg0 = stage.neg ? codes.minus :
                      ((stage.q1000 != '0) ? digit_pattern(d0) : codes.blank);

    assign packed_seg = (stage.kind == KIND_INT) ?
                        {int_seg3, int_seg2, int_seg1, int_seg0} : stage.seg;

    assign br_lsb = 4'({stage.display, 1'b0}) + 4'(stage.display);
    assign br     = brightness_codes[br_lsb +: 3];

    assign kind_ok  = (stage.kind == KIND_INT) || (stage.kind == KIND_RAW) ||
                      (stage.kind == KIND_TEXT);
    assign in_range = kind_ok && ({2'b00, stage.display} < DISPLAY_LIMIT) &&
                      attached_mask[stage.display];
    assign hit      = cache_valid_reg[idx] && (cache_seg_reg[idx] == packed_seg) &&
                      (cache_br_reg[idx] == br);
    assign emit     = in_range && !hit;

    assign last_byte   = (slot_reg == SLOT_CTRL);
    assign em_free     = !busy_reg || (frame_ready && last_byte);
    assign load        = stage_valid && emit && em_free;
    assign stage_ready = !emit || em_free;

    always_comb
    begin
        busy_next = busy_reg;
        slot_next = slot_reg;
        if (load)
        begin
            busy_next = 1'b1;
            slot_next = SLOT_DATA_CMD;
        end
        else if (busy_reg && frame_ready)
        begin
            if (last_byte)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                slot_next = frame_slot_t'(3'(slot_reg) + 3'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            slot_reg        <= SLOT_DATA_CMD;
            cache_valid_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            slot_reg <= slot_next;
            if (load)
            begin
                cache_valid_reg[idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tgt_reg            <= stage.display;
            seg_reg            <= packed_seg;
            br_reg             <= br;
            cache_seg_reg[idx] <= packed_seg;
            cache_br_reg[idx]  <= br;
        end
    end

    always_comb
    begin
        frame_byte   = '0;
        start_before = 1'b0;
        stop_after   = 1'b0;
        last         = 1'b0;
        unique case (slot_reg)
            SLOT_DATA_CMD:
            begin
                frame_byte   = CMD_DATA_AUTO;
                start_before = 1'b1;
                stop_after   = 1'b1;
            end
            SLOT_ADDR_CMD:
            begin
                frame_byte   = CMD_ADDR_START;
                start_before = 1'b1;
            end
            SLOT_DIGIT0: frame_byte = seg_reg[7:0];
            SLOT_DIGIT1: frame_byte = seg_reg[15:8];
            SLOT_DIGIT2: frame_byte = seg_reg[23:16];
            SLOT_DIGIT3:
            begin
                frame_byte = seg_reg[31:24];
                stop_after = 1'b1;
            end
            SLOT_CTRL:
            begin
                frame_byte   = CMD_DISPLAY_CTRL | {5'b00000, br_reg};
                start_before = 1'b1;
                stop_after   = 1'b1;
                last         = 1'b1;
            end
            default:
            begin
                frame_byte = '0;
            end
        endcase
    end

    assign frame_valid = busy_reg;
    assign target      = tgt_reg;

endmodule

[rtl/core/seven_segment_display_update.sv]
// Seven-segment display updater for up to four four-digit displays on a
// two-wire link. Each request names a display and carries a signed integer
// (clipped to -999..9999, right-aligned), four raw segment bytes, or four
// text characters. When the display is attached and the new segments or its
// brightness differ from what was last sent, the block emits seven frame
// bytes, one per cycle while frame_ready is high, on the frame channel: the
// data command, the address command, the four segment bytes and the display
// control byte, each marked with its start and stop conditions; the final
// byte carries last. Requests to a detached display, with an unknown kind,
// or with unchanged contents produce nothing. The request path is a
// two-stage pipeline (input register, then a divide stage built from
// reciprocal multiplies). A request that produces a frame occupies the byte
// sequencer until its last byte is taken; requests that are dropped pass
// at one per cycle unless held behind one waiting for the sequencer. The
// user must write configuration through the cfg port only while the block
// is idle; the block itself does not enforce this.
module seven_segment_display_update #(
    parameter int NUM_DISPLAYS = 4
) (
    input  logic               clk,
    input  logic               rst_n,

    // Request channel.
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [1:0]         kind,
    input  logic [1:0]         display,
    input  logic signed [15:0] number,
    input  logic [31:0]        segments,
    input  logic [31:0]        text,

    // Frame byte channel.
    output logic               frame_valid,
    input  logic               frame_ready,
    output logic [1:0]         target,
    output logic [7:0]         frame_byte,
    output logic               start_before,
    output logic               stop_after,
    output logic               last,

    // Configuration write port.
    input  logic                               cfg_we,
    input  logic [ssd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ssd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ssd_pkg::*;

    // Configuration registers. Brightness holds three bits per display,
    // display zero in the lowest bits.
    logic [11:0] brightness_reg;
    logic [3:0]  attached_reg;
    seg_codes_t  codes_reg;

    logic        stage_valid;
    logic        stage_ready;
    stage_t      stage;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg     <= 12'hFFF;
            attached_reg       <= 4'h0;
            codes_reg.blank    <= 8'h00;
            codes_reg.minus    <= 8'h40;
            codes_reg.dash     <= 8'h40;
            codes_reg.letter_e <= 8'h79;
            codes_reg.letter_r <= 8'h50;
            codes_reg.space    <= 8'h00;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BRIGHTNESS: brightness_reg     <= cfg_data;
                REG_ATTACHED:   attached_reg       <= cfg_data[3:0];
                REG_BLANK:      codes_reg.blank    <= cfg_data[7:0];
                REG_MINUS:      codes_reg.minus    <= cfg_data[7:0];
                REG_DASH:       codes_reg.dash     <= cfg_data[7:0];
                REG_LETTER_E:   codes_reg.letter_e <= cfg_data[7:0];
                REG_LETTER_R:   codes_reg.letter_r <= cfg_data[7:0];
                REG_SPACE:      codes_reg.space    <= cfg_data[7:0];
                default:        attached_reg       <= attached_reg;
            endcase
        end
    end

    // Input register, text mapping and the divide stage for integers.
    ssd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .kind        (kind),
        .display     (display),
        .number      (number),
        .segments    (segments),
        .text        (text),
        .codes       (codes_reg),
        .stage_valid (stage_valid),
        .stage_ready (stage_ready),
        .stage       (stage)
    );

    // Digit formatting, cache compare and the seven-byte frame sequencer.
    // The cache is written when a frame is committed to the sequencer, so a
    // following request to the same display compares against it directly.
    ssd_update #(
        .NUM_DISPLAYS (NUM_DISPLAYS)
    ) u_update (
        .clk              (clk),
        .rst_n            (rst_n),
        .stage_valid      (stage_valid),
        .stage_ready      (stage_ready),
        .stage            (stage),
        .brightness_codes (brightness_reg),
        .attached_mask    (attached_reg),
        .codes            (codes_reg),
        .frame_valid      (frame_valid),
        .frame_ready      (frame_ready),
        .target           (target),
        .frame_byte       (frame_byte),
        .start_before     (start_before),
        .stop_after       (stop_after),
        .last             (last)
    );

endmodule
